// ===== hdl/nfcs_pkg.sv =====
package nfcs_pkg;

    // Defaults for top-level parameters
    localparam int ADDR_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Request codes on the action field
    localparam logic [2:0] A_READ    = 3'd0;
    localparam logic [2:0] A_PROGRAM = 3'd1;
    localparam logic [2:0] A_ERASE   = 3'd2;
    localparam logic [2:0] A_READ_ID = 3'd3;
    localparam logic [2:0] A_RETURN  = 3'd4;

    // Command set addresses and data
    localparam logic [15:0] UNLOCK_ADDR_1 = 16'h0555;
    localparam logic [15:0] UNLOCK_ADDR_2 = 16'h02AA;
    localparam logic [15:0] ID_DEV_ADDR   = 16'h0001;
    localparam logic [7:0]  UNLOCK_DATA_1 = 8'hAA;
    localparam logic [7:0]  UNLOCK_DATA_2 = 8'h55;
    localparam logic [7:0]  CMD_PROGRAM   = 8'hA0;
    localparam logic [7:0]  CMD_ERASE     = 8'h80;
    localparam logic [7:0]  CMD_SECTOR    = 8'h30;
    localparam logic [7:0]  CMD_AUTOSEL   = 8'h90;
    localparam logic [7:0]  CMD_RESET     = 8'hF0;
    localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
    localparam int          POLL_DONE_BIT = 7;
    localparam int          POLL_FAIL_BIT = 5;

    // Result kinds
    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_DONE  = 2'd2
    } t_kind;

    // Jobs passed from the front end to the back end
    typedef enum logic [2:0] {
        J_READ   = 3'd0,   // single bus read at addr
        J_PROG   = 3'd1,   // program command sequence and first poll
        J_ERASE  = 3'd2,   // sector erase sequence and first poll
        J_ID     = 3'd3,   // autoselect entry and manufacturer read
        J_DONE   = 3'd4,   // completion with status and data
        J_ID_END = 3'd5    // reset write and completion with device id
    } t_job_op;

    typedef struct packed {
        t_job_op     op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        status;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/nfcs_front.sv =====
module nfcs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_action,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_sector,
    input  logic [7:0]        i_write_data,
    input  logic [7:0]        i_bus_return,
    output logic              o_push,
    output nfcs_pkg::t_job    o_job
);
    import nfcs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READ,
        PH_PROG,
        PH_ERASE,
        PH_IDMAN,
        PH_IDDEV
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_held_addr, n_held_addr;
    logic [7:0]  r_held_data, n_held_data;
    logic        n_push;
    t_job        n_job;

    // Classify the transaction against the current phase
    always_comb begin
        n_phase     = r_phase;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_push      = 1'b0;
        n_job       = '{op: J_READ, addr: 16'd0, data: 8'd0, status: 1'b0};
        if (r_phase == PH_IDLE) begin
            case (i_action)
                A_READ: begin
                    n_held_addr = i_address;
                    n_push      = 1'b1;
                    n_job.op    = J_READ;
                    n_job.addr  = i_address;
                    n_phase     = PH_READ;
                end
                A_PROGRAM: begin
                    n_held_addr = i_address;
                    n_held_data = i_write_data;
                    n_push      = 1'b1;
                    n_job.op    = J_PROG;
                    n_job.addr  = i_address;
                    n_job.data  = i_write_data;
                    n_phase     = PH_PROG;
                end
                A_ERASE: begin
                    n_held_addr = {i_sector, 8'd0};
                    n_push      = 1'b1;
                    n_job.op    = J_ERASE;
                    n_job.addr  = {i_sector, 8'd0};
                    n_phase     = PH_ERASE;
                end
                A_READ_ID: begin
                    n_held_addr = 16'd0;
                    n_push      = 1'b1;
                    n_job.op    = J_ID;
                    n_phase     = PH_IDMAN;
                end
                default: ;
            endcase
        end else if (i_action == A_RETURN) begin
            n_push = 1'b1;
            case (r_phase)
                PH_READ: begin
                    n_job.op   = J_DONE;
                    n_job.data = i_bus_return;
                    n_phase    = PH_IDLE;
                end
                PH_PROG: begin
                    if (i_bus_return[POLL_DONE_BIT] == r_held_data[POLL_DONE_BIT]) begin
                        n_job.op = J_DONE;
                        n_phase  = PH_IDLE;
                    end else if (i_bus_return[POLL_FAIL_BIT]) begin
                        n_job.op     = J_DONE;
                        n_job.status = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_job.op   = J_READ;
                        n_job.addr = r_held_addr;
                    end
                end
                PH_ERASE: begin
                    if (i_bus_return == ERASED_BYTE) begin
                        n_job.op = J_DONE;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_job.op   = J_READ;
                        n_job.addr = r_held_addr;
                    end
                end
                PH_IDMAN: begin
                    n_held_addr = ID_DEV_ADDR;
                    n_job.op    = J_READ;
                    n_job.addr  = ID_DEV_ADDR;
                    n_phase     = PH_IDDEV;
                end
                default: begin
                    n_job.op   = J_ID_END;
                    n_job.data = i_bus_return;
                    n_phase    = PH_IDLE;
                end
            endcase
        end
    end

    assign o_push = i_accept && n_push;
    assign o_job  = n_job;

    // Phase and held operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_held_addr <= 16'd0;
            r_held_data <= 8'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
        end
    end

endmodule

// ===== hdl/nfcs_queue.sv =====
module nfcs_queue #(
    parameter int DEPTH = nfcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nfcs_pkg::t_job    i_job,
    input  logic              i_pop,
    output nfcs_pkg::t_job    o_job,
    output nfcs_pkg::t_q_stat o_stat
);
    import nfcs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("job queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("job queue count out of range");

endmodule

// ===== hdl/nfcs_back.sv =====
module nfcs_back #(
    parameter int ADDR_WIDTH = nfcs_pkg::ADDR_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nfcs_pkg::t_job    i_job,
    input  nfcs_pkg::t_q_stat i_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [15:0]       o_bus_address,
    output logic [7:0]        o_bus_data,
    output logic              o_status,
    output logic [7:0]        o_result_data,
    output logic              o_last
);
    import nfcs_pkg::*;

    localparam int MW = (ADDR_WIDTH < 16) ? ADDR_WIDTH : 16;
    localparam logic [15:0] AMASK = 16'((17'd1 << MW) - 17'd1);

    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        status;
        logic [7:0]  result;
        logic        last;
    } t_beat;

    function automatic t_beat wr(input logic [15:0] a, input logic [7:0] d);
        t_beat b;
        b = '{kind: K_WRITE, addr: a, data: d, status: 1'b0, result: 8'd0, last: 1'b0};
        return b;
    endfunction

    function automatic t_beat rd(input logic [15:0] a);
        t_beat b;
        b = '{kind: K_READ, addr: a, data: 8'd0, status: 1'b0, result: 8'd0, last: 1'b1};
        return b;
    endfunction

    function automatic t_beat done(input logic s, input logic [7:0] r);
        t_beat b;
        b = '{kind: K_DONE, addr: 16'd0, data: 8'd0, status: s, result: r, last: 1'b1};
        return b;
    endfunction

    // One bus cycle of a job, chosen by its step number
    function automatic t_beat beat(input t_job j, input logic [2:0] idx);
        t_beat b;
        b = done(1'b0, 8'd0);
        case (j.op)
            J_READ: b = rd(j.addr);
            J_DONE: b = done(j.status, j.data);
            J_ID_END: begin
                if (idx == 3'd0) b = wr(ID_DEV_ADDR, CMD_RESET);
                else             b = done(1'b0, j.data);
            end
            J_PROG: begin
                case (idx)
                    3'd0:    b = wr(UNLOCK_ADDR_1, UNLOCK_DATA_1);
                    3'd1:    b = wr(UNLOCK_ADDR_2, UNLOCK_DATA_2);
                    3'd2:    b = wr(UNLOCK_ADDR_1, CMD_PROGRAM);
                    3'd3:    b = wr(j.addr, j.data);
                    default: b = rd(j.addr);
                endcase
            end
            J_ERASE: begin
                case (idx)
                    3'd0:    b = wr(UNLOCK_ADDR_1, UNLOCK_DATA_1);
                    3'd1:    b = wr(UNLOCK_ADDR_2, UNLOCK_DATA_2);
                    3'd2:    b = wr(UNLOCK_ADDR_1, CMD_ERASE);
                    3'd3:    b = wr(UNLOCK_ADDR_1, UNLOCK_DATA_1);
                    3'd4:    b = wr(UNLOCK_ADDR_2, UNLOCK_DATA_2);
                    3'd5:    b = wr(j.addr, CMD_SECTOR);
                    default: b = rd(j.addr);
                endcase
            end
            J_ID: begin
                case (idx)
                    3'd0:    b = wr(UNLOCK_ADDR_1, UNLOCK_DATA_1);
                    3'd1:    b = wr(UNLOCK_ADDR_2, UNLOCK_DATA_2);
                    3'd2:    b = wr(UNLOCK_ADDR_1, CMD_AUTOSEL);
                    default: b = rd(16'd0);
                endcase
            end
            default: ;
        endcase
        return b;
    endfunction

    t_beat      r_out;
    logic       r_valid;
    logic [2:0] r_step;
    t_beat      n_beat;
    t_beat      n_out;
    logic       n_load;

    assign n_beat = beat(i_job, r_step);
    assign n_load = !i_stat.empty && (!r_valid || i_ready);
    assign o_pop  = n_load && n_beat.last;

    // Bus address limited to the flash address width
    always_comb begin
        n_out      = n_beat;
        n_out.addr = n_beat.addr & AMASK;
    end

    // Output register and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else if (n_load) begin
            r_valid <= 1'b1;
            r_step  <= n_beat.last ? 3'd0 : r_step + 3'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_out.kind;
    assign o_bus_address = r_out.addr;
    assign o_bus_data    = r_out.data;
    assign o_status      = r_out.status;
    assign o_result_data = r_out.result;
    assign o_last        = r_out.last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= 3'd6)
        else $error("job step past longest sequence");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.kind == K_DONE |-> r_out.last)
        else $error("completion not marked last");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.kind == K_READ |-> r_out.data == 8'd0 && !r_out.status)
        else $error("read request carries data or status");

    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.empty |-> r_step == 3'd0)
        else $error("step counter moved with no job queued");

endmodule

// ===== hdl/nor_flash_command_sequencer.sv =====
// A transaction's first result is written into the job queue, then into the output register once it is free.
// Throughput: one result per cycle while the output is not stalled; a request emits 1 to 7 results.
// Input is accepted every cycle while the job queue has space.
// Sustained rate is set by the back-end step counter emitting one bus cycle per clock while the output is not stalled.
// Reset: synchronous active low; clears the phase, job queue and output valid.
module nor_flash_command_sequencer #(
    parameter int ADDR_WIDTH  = nfcs_pkg::ADDR_WIDTH_DEF,
    parameter int QUEUE_DEPTH = nfcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_sector,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_bus_return,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_bus_address,
    output logic [7:0]  o_bus_data,
    output logic        o_status,
    output logic [7:0]  o_result_data,
    output logic        o_last
);
    import nfcs_pkg::*;

    t_job    w_push_job, w_head_job;
    t_q_stat w_stat;
    logic    w_push, w_pop, w_accept;

    assign o_ready  = !w_stat.full;
    assign w_accept = i_valid && o_ready;

    // Front end: phase tracking and job classification
    nfcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_sector     (i_sector),
        .i_write_data (i_write_data),
        .i_bus_return (i_bus_return),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    // Job queue between the two halves
    nfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_stat)
    );

    // Back end: bus cycle sequencing
    nfcs_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_head_job),
        .i_stat        (w_stat),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_bus_address (o_bus_address),
        .o_bus_data    (o_bus_data),
        .o_status      (o_status),
        .o_result_data (o_result_data),
        .o_last        (o_last)
    );

endmodule
